/* src/uart_ring_buffers_unit_macros.svh */
// Assertion macros for the UART ring buffer unit.
// Used by the port-level checker; no other dependencies.
`ifndef UART_RING_BUFFERS_UNIT_MACROS_SVH
`define UART_RING_BUFFERS_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define URB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define URB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/urb_pkg.sv */
// Shared types for the UART ring buffer unit.
// No dependencies; imported by the controller, datapath, top level and checker.
`timescale 1ns / 1ps
`default_nettype none

package urb_pkg;

    typedef enum logic [1:0] {
        CMD_LINE_RX    = 2'd0,
        CMD_HOST_READ  = 2'd1,
        CMD_HOST_WRITE = 2'd2,
        CMD_TX_READY   = 2'd3
    } t_cmd;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_BUSY = 1'b1
    } t_state;

    // Controller to datapath command group.
    typedef struct packed {
        logic load;
        logic busy;
    } t_ctrl_cmd;

    localparam int DATA_W  = 8;
    localparam int COUNT_W = 4;
    localparam int OUT_W   = 24;

endpackage

`default_nettype wire

/* src/urb_ctrl.sv */
// Controller for the UART ring buffer unit: one transaction in flight.
// Depends on urb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urb_ctrl
    import urb_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_s_tvalid,
    input  wire logic      i_m_tready,
    output t_ctrl_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_BUSY;
            end
            S_BUSY: begin
                if (i_m_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:  o_cmd.load = i_s_tvalid;
            S_BUSY:  o_cmd.busy = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

/* src/urb_datapath.sv */
// Datapath for the UART ring buffer unit: both rings, pointers and result register.
// Depends on urb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urb_datapath
    import urb_pkg::*;
#(
    parameter int BUF_SIZE = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ctrl_cmd         i_cmd,
    input  wire logic [1:0]        i_op,
    input  wire logic [DATA_W-1:0] i_data,
    output logic [DATA_W-1:0]      o_read_byte,
    output logic                   o_line_valid,
    output logic [DATA_W-1:0]      o_line_byte,
    output logic                   o_dropped,
    output logic [COUNT_W-1:0]     o_rx_count,
    output logic                   o_tx_irq_on
);

    localparam int AW = (BUF_SIZE > 1) ? $clog2(BUF_SIZE) : 1;
    localparam int CW = (AW > COUNT_W) ? AW : COUNT_W;

    logic [DATA_W-1:0] rx_mem [BUF_SIZE];
    logic [DATA_W-1:0] tx_mem [BUF_SIZE];

    logic [AW-1:0] r_rx_head, r_rx_tail, r_tx_head, r_tx_tail;
    logic [AW-1:0] n_rx_head, n_rx_tail, n_tx_head, n_tx_tail;
    logic          r_tx_en, n_tx_en;
    logic          r_pop_rx, n_pop_rx;
    logic          r_pop_tx, n_pop_tx;
    logic          r_dropped, n_dropped;
    logic [DATA_W-1:0] r_rx_rdata, r_tx_rdata;

    logic          w_rx_we, w_tx_we;
    logic          w_rx_full, w_rx_empty, w_tx_full, w_tx_empty;
    logic [AW-1:0] w_rx_diff;
    logic [CW-1:0] w_rx_diff_ext;
    t_cmd          w_op;

    assign w_op       = t_cmd'(i_op);
    assign w_rx_full  = (r_rx_head + AW'(1)) == r_rx_tail;
    assign w_tx_full  = (r_tx_head + AW'(1)) == r_tx_tail;
    assign w_rx_empty = r_rx_head == r_rx_tail;
    assign w_tx_empty = r_tx_head == r_tx_tail;

    always_comb begin
        n_rx_head = r_rx_head;
        n_rx_tail = r_rx_tail;
        n_tx_head = r_tx_head;
        n_tx_tail = r_tx_tail;
        n_tx_en   = r_tx_en;
        n_pop_rx  = 1'b0;
        n_pop_tx  = 1'b0;
        n_dropped = 1'b0;
        w_rx_we   = 1'b0;
        w_tx_we   = 1'b0;
        case (w_op)
            CMD_LINE_RX: begin
                if (w_rx_full) begin
                    n_dropped = 1'b1;
                end else begin
                    w_rx_we   = 1'b1;
                    n_rx_head = r_rx_head + AW'(1);
                end
            end
            CMD_HOST_READ: begin
                if (!w_rx_empty) begin
                    n_pop_rx  = 1'b1;
                    n_rx_tail = r_rx_tail + AW'(1);
                end
            end
            CMD_HOST_WRITE: begin
                if (w_tx_full) begin
                    n_dropped = 1'b1;
                end else begin
                    w_tx_we   = 1'b1;
                    n_tx_head = r_tx_head + AW'(1);
                    n_tx_en   = 1'b1;
                end
            end
            CMD_TX_READY: begin
                // Drain one byte while enabled; an empty ring turns the interrupt off.
                if (r_tx_en) begin
                    if (w_tx_empty) begin
                        n_tx_en = 1'b0;
                    end else begin
                        n_pop_tx  = 1'b1;
                        n_tx_tail = r_tx_tail + AW'(1);
                    end
                end
            end
            default: n_dropped = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head <= '0;
            r_rx_tail <= '0;
            r_tx_head <= '0;
            r_tx_tail <= '0;
            r_tx_en   <= 1'b0;
        end else if (i_cmd.load) begin
            r_rx_head <= n_rx_head;
            r_rx_tail <= n_rx_tail;
            r_tx_head <= n_tx_head;
            r_tx_tail <= n_tx_tail;
            r_tx_en   <= n_tx_en;
        end
    end

    // Result flags are payload and held for the whole output transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pop_rx  <= n_pop_rx;
            r_pop_tx  <= n_pop_tx;
            r_dropped <= n_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_rx_we) rx_mem[r_rx_head] <= i_data;
        if (i_cmd.load) r_rx_rdata <= rx_mem[r_rx_tail];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_tx_we) tx_mem[r_tx_head] <= i_data;
        if (i_cmd.load) r_tx_rdata <= tx_mem[r_tx_tail];
    end

    assign w_rx_diff     = r_rx_head - r_rx_tail;
    assign w_rx_diff_ext = CW'(w_rx_diff);

    assign o_read_byte  = r_pop_rx ? r_rx_rdata : '0;
    assign o_line_valid = r_pop_tx;
    assign o_line_byte  = r_pop_tx ? r_tx_rdata : '0;
    assign o_dropped    = r_dropped;
    assign o_rx_count   = w_rx_diff_ext[COUNT_W-1:0];
    assign o_tx_irq_on  = r_tx_en & i_cmd.busy | r_tx_en & ~i_cmd.busy;

endmodule

`default_nettype wire

/* src/uart_ring_buffers_unit.sv */
// Top level of the UART ring buffer unit: receive and transmit rings between line and host.
// Depends on urb_pkg, urb_ctrl and urb_datapath.
//
// Usage:
//   Slave channel carries one event per transaction: tuser is the command
//   (line byte received, host read, host write, transmitter ready) and tdata
//   the byte pushed by the two push commands.
//   Master channel returns exactly one result per event.
//   Latency: the result is valid the cycle after the input transaction.
//   The controller holds one event at a time, so no new event is taken until
//   the result of the last one is accepted; the ring read is a registered
//   memory port sampled at the input transaction.
//   Reset (synchronous, active low) empties both rings and clears the
//   transmit interrupt enable; ring contents are not cleared.
//   When the receiver stalls, the result is held and no new event is taken
//   until it is accepted.
//   Ring depth is BUF_SIZE (a power of two); one slot always stays free.
`timescale 1ns / 1ps
`default_nettype none

module uart_ring_buffers_unit
    import urb_pkg::*;
#(
    parameter int BUF_SIZE = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic [7:0]       i_s_tdata,   // [7:0] data
    input  wire logic [1:0]       i_s_tuser,   // [1:0] cmd
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic [OUT_W-1:0]      o_m_tdata    // [7:0] read_byte, [8] line_valid,
                                               // [16:9] line_byte, [17] dropped,
                                               // [21:18] rx_count, [22] tx_irq_on,
                                               // [23] zero
);

    t_ctrl_cmd            w_cmd;
    logic [DATA_W-1:0]    w_read_byte, w_line_byte;
    logic                 w_line_valid, w_dropped, w_tx_irq_on;
    logic [COUNT_W-1:0]   w_rx_count;
    logic                 w_busy_q;

    urb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    urb_datapath #(
        .BUF_SIZE (BUF_SIZE)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_op         (i_s_tuser),
        .i_data       (i_s_tdata),
        .o_read_byte  (w_read_byte),
        .o_line_valid (w_line_valid),
        .o_line_byte  (w_line_byte),
        .o_dropped    (w_dropped),
        .o_rx_count   (w_rx_count),
        .o_tx_irq_on  (w_tx_irq_on)
    );

    assign w_busy_q   = w_cmd.busy;
    assign o_s_tready = ~w_busy_q;
    assign o_m_tvalid = w_busy_q;
    assign o_m_tdata  = {1'b0, w_tx_irq_on, w_rx_count, w_dropped, w_line_byte,
                         w_line_valid, w_read_byte};

endmodule

`default_nettype wire

/* src/urb_checker.sv */
// Port-level checker for the UART ring buffer unit, bound to the top level.
// Depends on uart_ring_buffers_unit_macros.svh and urb_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "uart_ring_buffers_unit_macros.svh"

module urb_checker
    import urb_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_s_tvalid,
    input wire logic             o_s_tready,
    input wire logic             o_m_tvalid,
    input wire logic             i_m_tready,
    input wire logic [OUT_W-1:0] o_m_tdata
);

    logic w_in_xfer;
    logic w_out_stall;

    assign w_in_xfer   = i_s_tvalid & o_s_tready;
    assign w_out_stall = o_m_tvalid & ~i_m_tready;

    `URB_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, w_out_stall, o_m_tvalid && $stable(o_m_tdata), "result changed while stalled")
    `URB_ASSERT_NOW(a_one_in_flight, i_clk, i_rst_n, o_m_tvalid, !o_s_tready, "input accepted while a result is pending")
    `URB_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, w_in_xfer, o_m_tvalid, "no result after input transaction")
    `URB_ASSERT_NOW(a_line_excl, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[8], o_m_tdata[7:0] == 8'd0 && !o_m_tdata[17], "line byte sent together with host byte or drop")

endmodule

bind uart_ring_buffers_unit urb_checker u_urb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
